>>> rtl/rm1dec_pkg.sv
// shared constants for the first-order reed-muller decoder
// no dependencies; used by reed_muller_first_order_decoder

package rm1dec_pkg;

  // width of the received word port
  localparam int WORD_BITS = 32;

  // width of the linear message bits port
  localparam int LIN_BITS = 5;

endpackage

>>> rtl/reed_muller_first_order_decoder.sv
// reed_muller_first_order_decoder: decodes one first-order reed-muller codeword of
// 2^CODE_ORDER bits per request into a constant bit and CODE_ORDER linear bits
// (the low five of them reach linear_bits). Each codeword bit becomes +1 or -1, a fast
// hadamard transform runs as CODE_ORDER registered butterfly stages, and a registered
// pairwise compare tree of CODE_ORDER levels finds the largest magnitude, lowest index
// on ties. One request enters every cycle while in_stall is low; the pipeline holds one
// register per butterfly stage and one per tree level, plus the input and output registers.
// Each stage holds while the one after it is full and stalled, so empty stages still fill
// while a result waits. Depends on rm1dec_pkg.

module reed_muller_first_order_decoder #(
  parameter int CODE_ORDER = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rm1dec_pkg::WORD_BITS-1:0]    received_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                constant_bit,
  output logic [rm1dec_pkg::LIN_BITS-1:0]     linear_bits
);

  localparam int N = 1 << CODE_ORDER;
  localparam int W = CODE_ORDER + 2;
  localparam int S = 2 * CODE_ORDER + 2;

  logic [S-1:0] v;
  logic [S-1:0] rdy;

  logic [N-1:0] word_map;
  logic [N-1:0] wreg;

  logic signed [W-1:0] bsrc [CODE_ORDER][N];
  logic signed [W-1:0] bf   [CODE_ORDER][N];

  logic signed [W-1:0]      cval [CODE_ORDER+1][N];
  logic [CODE_ORDER-1:0]    cpos [CODE_ORDER+1][N];
  logic signed [W-1:0]      tv   [CODE_ORDER][N];
  logic [CODE_ORDER-1:0]    tp   [CODE_ORDER][N];

  logic                                cbit;
  logic [rm1dec_pkg::LIN_BITS-1:0]     lin;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? W'(-x) : W'(x);
  endfunction

  // handshake chain
  assign rdy[S-1] = !v[S-1] || !out_stall;
  for (genvar s = 0; s < S - 1; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[S-1];

  // codeword positions beyond the port read as zero
  for (genvar g = 0; g < N; g++) begin : g_map
    if (g < rm1dec_pkg::WORD_BITS) begin : g_in
      assign word_map[g] = received_word[g];
    end else begin : g_zero
      assign word_map[g] = 1'b0;
    end
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      bsrc[0][j] = wreg[j] ? W'(1) : W'(-1);
      cval[0][j] = bf[CODE_ORDER-1][j];
      cpos[0][j] = CODE_ORDER'(j);
    end
    for (int b = 1; b < CODE_ORDER; b++) begin
      for (int j = 0; j < N; j++) begin
        bsrc[b][j] = bf[b-1][j];
      end
    end
    for (int b = 1; b <= CODE_ORDER; b++) begin
      for (int j = 0; j < N; j++) begin
        cval[b][j] = tv[b-1][j];
        cpos[b][j] = tp[b-1][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < S; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      wreg <= word_map;
    end
    // butterfly stages, span 1, 2, 4, ...
    for (int b = 0; b < CODE_ORDER; b++) begin
      if (rdy[b+1]) begin
        for (int j = 0; j < N; j++) begin
          if ((j & (1 << b)) != 0) begin
            bf[b][j] <= bsrc[b][j ^ (1 << b)] - bsrc[b][j];
          end else begin
            bf[b][j] <= bsrc[b][j] + bsrc[b][j ^ (1 << b)];
          end
        end
      end
    end
    // compare tree, left candidate keeps ties
    for (int l = 0; l < CODE_ORDER; l++) begin
      if (rdy[CODE_ORDER+1+l]) begin
        for (int k = 0; k < (N >> (l + 1)); k++) begin
          if (mag(cval[l][2*k+1]) > mag(cval[l][2*k])) begin
            tv[l][k] <= cval[l][2*k+1];
            tp[l][k] <= cpos[l][2*k+1];
          end else begin
            tv[l][k] <= cval[l][2*k];
            tp[l][k] <= cpos[l][2*k];
          end
        end
      end
    end
    if (rdy[S-1]) begin
      cbit <= (cval[CODE_ORDER][0] > 0);
      lin  <= rm1dec_pkg::LIN_BITS'(cpos[CODE_ORDER][0]);
    end
  end

  assign constant_bit = cbit;
  assign linear_bits  = lin;

`ifndef SYNTHESIS
  // a stall toward the source only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled with an empty stage");

  // occupancy tracks accepted requests in and results out
  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(v) == $countones($past(v))
      + ($past(in_valid && !in_stall) ? 1 : 0)
      - ($past(out_valid && !out_stall) ? 1 : 0)))
    else $error("pipeline occupancy mismatch");

  // a request in the last tree level moves to the output when not blocked
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v[S-2] && !out_stall) |=> out_valid)
    else $error("result lost before output");
`endif

endmodule

>>> bench/tb_reed_muller_first_order_decoder.sv
// testbench for reed_muller_first_order_decoder: drives codewords with random idling on both
// channels and checks each decision against an in-bench hadamard-transform predictor
// depends on rm1dec_pkg and the reed_muller_first_order_decoder rtl
`timescale 1ns / 1ps

module tb_reed_muller_first_order_decoder;

  localparam int CODE_ORDER = 5;
  localparam int WORD_LEN = 1 << CODE_ORDER;
  localparam int SPAN = (WORD_LEN < rm1dec_pkg::WORD_BITS) ? WORD_LEN : rm1dec_pkg::WORD_BITS;
  localparam int LATENCY = 2 * CODE_ORDER + 2;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic                            cbit;
    logic [rm1dec_pkg::LIN_BITS-1:0] lin;
  } decision_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [rm1dec_pkg::WORD_BITS-1:0] received_word = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             constant_bit;
  logic [rm1dec_pkg::LIN_BITS-1:0]  linear_bits;

  decision_t pending_decisions[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        steady = 1'b0;

  always #6 clk = ~clk;

  reed_muller_first_order_decoder #(.CODE_ORDER(CODE_ORDER)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .received_word(received_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .constant_bit(constant_bit),
    .linear_bits(linear_bits)
  );

  function automatic decision_t predict_decision(logic [rm1dec_pkg::WORD_BITS-1:0] word);
    int        corr[64];
    int        h, blk, j, a, b, mag, best_mag, best_val, best_pos;
    decision_t d;
    for (j = 0; j < WORD_LEN; j++) begin
      corr[j] = (j < rm1dec_pkg::WORD_BITS && word[j] === 1'b1) ? 1 : -1;
    end
    for (h = 1; h < WORD_LEN; h = h * 2) begin
      for (blk = 0; blk < WORD_LEN; blk += 2 * h) begin
        for (j = blk; j < blk + h; j++) begin
          a = corr[j];
          b = corr[j + h];
          corr[j] = a + b;
          corr[j + h] = a - b;
        end
      end
    end
    best_pos = 0;
    best_val = corr[0];
    best_mag = (corr[0] < 0) ? -corr[0] : corr[0];
    for (j = 1; j < WORD_LEN; j++) begin
      mag = (corr[j] < 0) ? -corr[j] : corr[j];
      if (mag > best_mag) begin
        best_mag = mag;
        best_val = corr[j];
        best_pos = j;
      end
    end
    d.cbit = (best_val > 0);
    d.lin = best_pos[rm1dec_pkg::LIN_BITS-1:0];
    return d;
  endfunction

  // unused high bits are left random
  function automatic logic [rm1dec_pkg::WORD_BITS-1:0] encode_word(int msg, bit cbit);
    logic [rm1dec_pkg::WORD_BITS-1:0] w;
    int                               j;
    w = $urandom;
    for (j = 0; j < SPAN; j++) begin
      w[j] = cbit ^ (^(msg & j));
    end
    return w;
  endfunction

  function automatic logic [rm1dec_pkg::WORD_BITS-1:0] corrupt_word(
      logic [rm1dec_pkg::WORD_BITS-1:0] word, int flips);
    int pos;
    repeat (flips) begin
      pos = $urandom_range(0, SPAN - 1);
      word[pos] = ~word[pos];
    end
    return word;
  endfunction

  // halfway between two codewords, so both indexes see the same magnitude
  function automatic logic [rm1dec_pkg::WORD_BITS-1:0] tie_word(int msg_a, int msg_b);
    logic [rm1dec_pkg::WORD_BITS-1:0] wa, wb;
    int                               j, flips;
    wa = encode_word(msg_a, 1'b1);
    wb = encode_word(msg_b, 1'b1);
    flips = 0;
    for (j = 0; j < SPAN; j++) begin
      if (wa[j] != wb[j] && flips < WORD_LEN / 4) begin
        wa[j] = wb[j];
        flips++;
      end
    end
    return wa;
  endfunction

  task automatic send_word(logic [rm1dec_pkg::WORD_BITS-1:0] word);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    received_word <= word;
    do @(posedge clk); while (in_stall);
    pending_decisions = {pending_decisions, predict_decision(word)};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  task automatic send_noisy_codeword();
    send_word(corrupt_word(encode_word($urandom_range(0, WORD_LEN - 1),
                                       1'($urandom_range(0, 1))),
                           $urandom_range(0, WORD_LEN / 4)));
  endtask

  task automatic test_extreme_words();
    send_word('0);
    send_word('1);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    send_word(32'hFFFF_0000);
    send_word(32'h0000_FFFF);
    send_word(32'h0000_0001);
    send_word(32'h8000_0000);
    send_word(encode_word(WORD_LEN - 1, 1'b1));
    send_word(encode_word(WORD_LEN - 1, 1'b0));
    send_word(encode_word(0, 1'b1));
    send_word(encode_word(0, 1'b0));
    send_word(corrupt_word(encode_word(21 % WORD_LEN, 1'b1), 1));
    send_word(tie_word(0, WORD_LEN - 1));
    send_word(tie_word(6 % WORD_LEN, 9 % WORD_LEN));
  endtask

  task automatic test_noisy_codewords(int count);
    repeat (count) send_noisy_codeword();
  endtask

  task automatic test_back_to_back(int count);
    steady = 1'b1;
    repeat (count) begin
      if ($urandom_range(0, 1)) send_noisy_codeword();
      else send_word($urandom);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_words(int count);
    repeat (count) send_word($urandom);
  endtask

  initial begin : result_stall
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : decision_check
    decision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual cbit=%0b lin=%0d",
                 $time, constant_bit, linear_bits);
      end else begin
        want = pending_decisions.pop_front();
        if (constant_bit !== want.cbit) begin
          errors++;
          $display("%0t: constant_bit expected %0b actual %0b", $time, want.cbit, constant_bit);
        end
        if (linear_bits !== want.lin) begin
          errors++;
          $display("%0t: linear_bits expected %0d actual %0d", $time, want.lin, linear_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_extreme_words();
    wait_drained();
    test_noisy_codewords(550);
    wait_drained();
    test_back_to_back(150);
    test_random_words(300);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
